### rtl/button_press_qualifier_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the button press qualifier
// Shared shorthand for clocked implication checks with reset disable.
// ---------------------------------------------------------------------------
`ifndef BUTTON_PRESS_QUALIFIER_TOP_ASSERT_SVH
`define BUTTON_PRESS_QUALIFIER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BPQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("button press qualifier: property violated");

// Next-cycle implication, disabled during reset.
`define BPQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("button press qualifier: property violated");

`endif

### rtl/bpq_pkg.sv
// ---------------------------------------------------------------------------
// Button press qualifier package
// Event codes, register indexes and the structures passed between modules.
// ---------------------------------------------------------------------------
package bpq_pkg;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_STARTED = 3'd1,
    EV_VALID   = 3'd2,
    EV_NOPRIV  = 3'd3,
    EV_LOCKOUT = 3'd4,
    EV_TIMEOUT = 3'd5,
    EV_ZONE    = 3'd6
  } bpq_event_t;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 16;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ACTIVE_LOW       = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEBOUNCE_MS      = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LOCKOUT_MS       = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HOLD_TIMEOUT_MS  = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RECENT_WINDOW_MS = 3'd4;

  localparam logic        RST_ACTIVE_LOW       = 1'b1;
  localparam logic [15:0] RST_DEBOUNCE_MS      = 16'd50;
  localparam logic [15:0] RST_LOCKOUT_MS       = 16'd1000;
  localparam logic [15:0] RST_HOLD_TIMEOUT_MS  = 16'd5000;
  localparam logic [15:0] RST_RECENT_WINDOW_MS = 16'd50;

  typedef struct packed {
    logic        active_low;
    logic [15:0] debounce_ms;
    logic [15:0] lockout_ms;
    logic [15:0] hold_timeout_ms;
    logic [15:0] recent_window_ms;
  } bpq_cfg_t;

  typedef struct packed {
    logic raw_level;
    logic priv_write;
    logic priv_value;
    logic zone_write;
    logic zone_value;
  } bpq_tick_t;

  typedef struct packed {
    bpq_event_t event_code;
    logic       stable_pressed;
    logic       held;
    logic       hold_timed_out;
    logic       locked_out;
    logic       recent_press;
  } bpq_result_t;

endpackage

### rtl/button_press_qualifier_top.sv
// ---------------------------------------------------------------------------
// Button press qualifier
// Debounces one push button per millisecond tick and qualifies each press.
//
// Each input word is one tick carrying the raw pin level and optional
// privilege and zone writes. Each tick yields exactly one result word with
// an event code and the held, timeout, lockout and recent-press flags.
// A word is taken on the input when in_valid is high and in_stall is low,
// and delivered when out_valid is high and out_stall is low.
// The block takes one word per cycle while in_stall is low; an accepted word
// passes through the input register and then the result register.
// When the receiver stalls, the result register holds its word and the
// input register takes one more; after that in_stall rises.
// Configuration registers are written through cfg_valid, cfg_index and
// cfg_data, with cfg_ready always high; the user must write them only while
// the block is idle; the block does not enforce it. Reset clears all tick
// state, restores the register defaults and empties both pipeline registers.
// ---------------------------------------------------------------------------
module button_press_qualifier_top import bpq_pkg::*; #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       raw_level,
  input  logic                       priv_write,
  input  logic                       priv_value,
  input  logic                       zone_write,
  input  logic                       zone_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 event_code,
  output logic                       stable_pressed,
  output logic                       held,
  output logic                       hold_timed_out,
  output logic                       locked_out,
  output logic                       recent_press,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  bpq_cfg_t    cfg;
  bpq_tick_t   tick;
  bpq_result_t step_result;
  bpq_result_t result;
  logic        in_full;
  logic        advance;
  logic        in_accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_low       <= RST_ACTIVE_LOW;
      cfg.debounce_ms      <= RST_DEBOUNCE_MS;
      cfg.lockout_ms       <= RST_LOCKOUT_MS;
      cfg.hold_timeout_ms  <= RST_HOLD_TIMEOUT_MS;
      cfg.recent_window_ms <= RST_RECENT_WINDOW_MS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ACTIVE_LOW:       cfg.active_low       <= cfg_data[0];
        CFG_DEBOUNCE_MS:      cfg.debounce_ms      <= cfg_data;
        CFG_LOCKOUT_MS:       cfg.lockout_ms       <= cfg_data;
        CFG_HOLD_TIMEOUT_MS:  cfg.hold_timeout_ms  <= cfg_data;
        CFG_RECENT_WINDOW_MS: cfg.recent_window_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance   = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      tick.raw_level  <= raw_level;
      tick.priv_write <= priv_write;
      tick.priv_value <= priv_value;
      tick.zone_write <= zone_write;
      tick.zone_value <= zone_value;
    end
  end

  bpq_core #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .cfg    (cfg),
    .tick   (tick),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

  assign event_code     = result.event_code;
  assign stable_pressed = result.stable_pressed;
  assign held           = result.held;
  assign hold_timed_out = result.hold_timed_out;
  assign locked_out     = result.locked_out;
  assign recent_press   = result.recent_press;

endmodule

### rtl/bpq_core.sv
// ---------------------------------------------------------------------------
// Button press qualifier core
// Holds the tick state and computes one tick's update and result word.
// ---------------------------------------------------------------------------
module bpq_core import bpq_pkg::*; #(
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  bpq_cfg_t    cfg,
  input  bpq_tick_t   tick,
  output bpq_result_t result
);

  logic [TIME_WIDTH-1:0] time_now, time_now_next;
  logic [TIME_WIDTH-1:0] debounce_start, debounce_start_next;
  logic [TIME_WIDTH-1:0] press_start, press_start_next;
  logic [TIME_WIDTH-1:0] last_valid_time, last_valid_time_next;
  logic                  raw_seen, raw_seen_next;
  logic                  stable_level, stable_level_next;
  logic                  press_active, press_active_next;
  logic                  last_valid_seen, last_valid_seen_next;
  logic                  privilege, privilege_next;
  logic                  in_zone, in_zone_next;

  logic                  raw;
  bpq_event_t            ev;
  logic [TIME_WIDTH-1:0] debounce_age;
  logic [TIME_WIDTH-1:0] press_age_old;
  logic [TIME_WIDTH-1:0] valid_age_old;
  logic [TIME_WIDTH-1:0] press_age;
  logic [TIME_WIDTH-1:0] valid_age;
  logic                  lockout_old;

  always_comb begin
    raw                  = tick.raw_level ^ cfg.active_low;
    ev                   = EV_NONE;
    in_zone_next         = in_zone;
    privilege_next       = privilege;
    press_active_next    = press_active;
    press_start_next     = press_start;
    raw_seen_next        = raw_seen;
    debounce_start_next  = debounce_start;
    stable_level_next    = stable_level;
    last_valid_time_next = last_valid_time;
    last_valid_seen_next = last_valid_seen;
    time_now_next        = time_now + TIME_WIDTH'(1);

    press_age_old = time_now - press_start;
    valid_age_old = time_now - last_valid_time;
    lockout_old   = last_valid_seen && (valid_age_old < TIME_WIDTH'(cfg.lockout_ms));

    if (tick.zone_write) begin
      if (in_zone && !tick.zone_value) begin
        press_active_next = 1'b0;
        press_start_next  = '0;
        privilege_next    = 1'b0;
        ev                = EV_ZONE;
      end
      in_zone_next = tick.zone_value;
    end
    if (tick.priv_write) begin
      privilege_next = tick.priv_value;
    end

    debounce_age = '0;
    if (!in_zone_next && press_active_next) begin
      press_active_next = 1'b0;
      press_start_next  = '0;
      privilege_next    = 1'b0;
      ev                = EV_ZONE;
    end else begin
      if (raw != raw_seen) begin
        raw_seen_next       = raw;
        debounce_start_next = time_now;
      end
      debounce_age = time_now - debounce_start_next;
      if (debounce_age >= TIME_WIDTH'(cfg.debounce_ms)) begin
        stable_level_next = raw_seen_next;
      end

      if (stable_level_next && !press_active_next) begin
        if (!privilege_next) begin
          ev = EV_NOPRIV;
        end else if (lockout_old) begin
          ev = EV_LOCKOUT;
        end else begin
          press_active_next = 1'b1;
          press_start_next  = time_now;
          ev                = EV_STARTED;
        end
      end else if (!stable_level_next && press_active_next) begin
        if (press_age_old >= TIME_WIDTH'(cfg.hold_timeout_ms)) begin
          ev = EV_TIMEOUT;
        end else begin
          last_valid_time_next = time_now;
          last_valid_seen_next = 1'b1;
          ev                   = EV_VALID;
        end
        press_active_next = 1'b0;
      end
    end

    press_age = time_now - press_start_next;
    valid_age = time_now - last_valid_time_next;

    result.event_code     = ev;
    result.stable_pressed = stable_level_next;
    result.held           = press_active_next;
    result.hold_timed_out = press_active_next &&
                            (press_age >= TIME_WIDTH'(cfg.hold_timeout_ms));
    result.locked_out     = last_valid_seen_next &&
                            (valid_age < TIME_WIDTH'(cfg.lockout_ms));
    result.recent_press   = !press_active_next && last_valid_seen_next &&
                            (valid_age < TIME_WIDTH'(cfg.recent_window_ms));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now        <= '0;
      debounce_start  <= '0;
      press_start     <= '0;
      last_valid_time <= '0;
      raw_seen        <= 1'b0;
      stable_level    <= 1'b0;
      press_active    <= 1'b0;
      last_valid_seen <= 1'b0;
      privilege       <= 1'b0;
      in_zone         <= 1'b0;
    end else if (fire) begin
      time_now        <= time_now_next;
      debounce_start  <= debounce_start_next;
      press_start     <= press_start_next;
      last_valid_time <= last_valid_time_next;
      raw_seen        <= raw_seen_next;
      stable_level    <= stable_level_next;
      press_active    <= press_active_next;
      last_valid_seen <= last_valid_seen_next;
      privilege       <= privilege_next;
      in_zone         <= in_zone_next;
    end
  end

endmodule

### rtl/bpq_checker.sv
// ---------------------------------------------------------------------------
// Button press qualifier checker
// Port-level properties of the result stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "button_press_qualifier_top_assert.svh"

module bpq_checker import bpq_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       raw_level,
  input logic                       priv_write,
  input logic                       priv_value,
  input logic                       zone_write,
  input logic                       zone_value,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [2:0]                 event_code,
  input logic                       stable_pressed,
  input logic                       held,
  input logic                       hold_timed_out,
  input logic                       locked_out,
  input logic                       recent_press,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  logic unused_inputs;

  assign unused_inputs = ^{in_valid, in_stall, raw_level, priv_write, priv_value,
                           zone_write, zone_value, locked_out, cfg_valid,
                           cfg_ready, cfg_index, cfg_data};

  `BPQ_ASSERT_NXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(event_code) && $stable(held) && $stable(stable_pressed))

  `BPQ_ASSERT_IMP(a_started_held, out_valid && (event_code == EV_STARTED),
    held && stable_pressed)

  `BPQ_ASSERT_IMP(a_end_not_held,
    out_valid && (event_code == EV_VALID || event_code == EV_TIMEOUT ||
    event_code == EV_ZONE), !held && !hold_timed_out)

  `BPQ_ASSERT_IMP(a_held_pressed, out_valid && held, stable_pressed && !recent_press)

endmodule

bind button_press_qualifier_top bpq_checker u_bpq_checker (.*);
